/* rtl/conv3x3_edge_smooth_filter_assert.svh */
// Assertion macros for the 3x3 window filter checker.
// Needs nothing else; include with the bare file name.
`ifndef CONV3X3_EDGE_SMOOTH_FILTER_ASSERT_SVH
`define CONV3X3_EDGE_SMOOTH_FILTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define C3ESF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("c3esf assertion failed");

// next-cycle implication, disabled in reset
`define C3ESF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("c3esf assertion failed");

`endif

/* rtl/c3esf_pkg.sv */
// Shared constants, codes and types of the 3x3 window filter.
// No dependencies; imported by the top level, both checkers and the bench top.
package c3esf_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);

    localparam int PixW      = 8;
    localparam int OutPosW   = 10;
    localparam int OutDataW  = 32;
    localparam int CfgW      = 11;
    localparam int CfgIdxW   = 2;
    localparam int ModeW     = 3;

    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd2;

    localparam logic [ModeW-1:0] MODE_AVG     = 3'd0;
    localparam logic [ModeW-1:0] MODE_GAUSS   = 3'd1;
    localparam logic [ModeW-1:0] MODE_PREWX   = 3'd2;
    localparam logic [ModeW-1:0] MODE_PREWY   = 3'd3;
    localparam logic [ModeW-1:0] MODE_SOBELX  = 3'd4;
    localparam logic [ModeW-1:0] MODE_SOBELY  = 3'd5;
    localparam logic [ModeW-1:0] MODE_LAPLACE = 3'd6;
    localparam logic [ModeW-1:0] MODE_SHARPEN = 3'd7;

    // signed window sum and its magnitude
    localparam int AccW = 13;
    localparam int MagW = 12;

    // floor(x * 11111 / 100000) as a scaled reciprocal
    localparam int AvgShift = 32;
    localparam longint unsigned AvgMul =
        ((64'd11111 << AvgShift) + 64'd99999) / 64'd100000;
    localparam int MulW = $clog2(AvgMul + 1);
    localparam int ProdW = MagW + MulW;

    // floor(x / 3) for x up to 765
    localparam int Div3Shift = 11;
    localparam longint unsigned Div3Mul = (64'd1 << Div3Shift) / 64'd3 + 64'd1;

    localparam int FifoDepth = 8;
    localparam int FifoAw    = $clog2(FifoDepth);

    typedef struct packed {
        logic [OutPosW-1:0] row;
        logic [OutPosW-1:0] col;
        logic               last;
    } pos_t;

    typedef struct packed {
        pos_t            pos;
        logic [PixW-1:0] pix;
    } result_t;

endpackage

/* rtl/conv3x3_edge_smooth_filter.sv */
// Streaming 3x3 convolution filter: line memory, window, arithmetic and result queue.
// Depends on c3esf_pkg.
// A result passes the memory read, window, sum and magnitude/product registers into the result queue.
// Throughput: one pixel per cycle while s_tready is high, set by one read and one write of the line memory per pixel.
// s_tready drops only when the 8-entry result queue plus results in flight would overflow.
// Reset: position zero, width and height 512, mode 0, window zero; line memory not cleared.
module conv3x3_edge_smooth_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel_in
    input  logic [0:0]                    s_tuser,   // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [c3esf_pkg::OutDataW-1:0] m_tdata,  // [7:0] pixel_out, [17:8] out_row,
                                                     // [27:18] out_col, [31:28] zero
    output logic                          m_tlast,   // frame_done
    input  logic                          cfg_we,
    input  logic [c3esf_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [c3esf_pkg::CfgW-1:0]    cfg_data
);
    import c3esf_pkg::*;

    // configuration
    logic [ColW-1:0]  wlast_reg;
    logic [RowW-1:0]  hlast_reg;
    logic [ModeW-1:0] mode_reg;
    logic [CfgW-1:0]  w_clamp;
    logic [CfgW-1:0]  h_clamp;

    // position
    logic [ColW-1:0] col_reg;
    logic [ColW-1:0] col_next;
    logic [RowW-1:0] row_reg;
    logic [RowW-1:0] row_next;
    logic [ColW-1:0] in_col;
    logic [RowW-1:0] in_row;
    logic            in_emit;
    pos_t            in_pos;
    logic            accept;

    // line memory: {row before previous, previous row}
    logic [2*PixW-1:0] line_mem [MaxWidth];
    logic [2*PixW-1:0] rd_data_reg;
    logic              fwd_hit_reg;
    logic [2*PixW-1:0] fwd_data_reg;
    logic [2*PixW-1:0] cur_entry;
    logic [PixW-1:0]   top_pix;
    logic [PixW-1:0]   mid_pix;

    // stage 1: memory data ready
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic [ColW-1:0] s1_col_reg;
    logic [PixW-1:0] s1_pix_reg;
    pos_t            s1_pos_reg;

    // stage 2: window holds the item
    logic [PixW-1:0] win_reg [9];
    logic            s2_valid_reg;
    pos_t            s2_pos_reg;
    logic signed [AccW-1:0] q [9];
    logic signed [AccW-1:0] ring;
    logic signed [AccW-1:0] acc_next;

    // stage 3: signed sum
    logic                   s3_valid_reg;
    pos_t                   s3_pos_reg;
    logic signed [AccW-1:0] acc_reg;
    logic [MagW-1:0]        mag_next;
    logic [MulW-1:0]        mul_const;

    // stage 4: magnitude and product
    logic            s4_valid_reg;
    pos_t            s4_pos_reg;
    logic [MagW-1:0] mag_reg;
    logic            neg_reg;
    logic [ProdW-1:0] prod_reg;
    logic [PixW-1:0] res_pix;

    // result queue
    result_t          fifo_mem [FifoDepth];
    logic [FifoAw-1:0] wr_ptr_reg;
    logic [FifoAw-1:0] rd_ptr_reg;
    logic [FifoAw:0]   count_reg;
    logic [2:0]        inflight;
    logic [FifoAw+1:0] occupancy;
    logic              push;
    logic              pop;
    result_t           head;

    always_comb
    begin
        if (cfg_data < CfgW'(3))
            w_clamp = CfgW'(3);
        else if (cfg_data > CfgW'(MaxWidth))
            w_clamp = CfgW'(MaxWidth);
        else
            w_clamp = cfg_data;
        if (cfg_data < CfgW'(3))
            h_clamp = CfgW'(3);
        else if (cfg_data > CfgW'(MaxHeight))
            h_clamp = CfgW'(MaxHeight);
        else
            h_clamp = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= ColW'(511);
            hlast_reg <= RowW'(511);
            mode_reg  <= MODE_AVG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  wlast_reg <= ColW'(w_clamp - CfgW'(1));
                CFG_HEIGHT: hlast_reg <= RowW'(h_clamp - CfgW'(1));
                CFG_MODE:   mode_reg  <= cfg_data[ModeW-1:0];
                default:    ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        in_col  = s_tuser[0] ? '0 : col_reg;
        in_row  = s_tuser[0] ? '0 : row_reg;
        in_emit = (in_row >= RowW'(2)) && (in_col >= ColW'(2))
                  && (in_row <= hlast_reg) && (in_col <= wlast_reg);
        in_pos.row  = OutPosW'(in_row - RowW'(1));
        in_pos.col  = OutPosW'(in_col - ColW'(1));
        in_pos.last = (in_row == hlast_reg) && (in_col == wlast_reg);
        if (in_col >= wlast_reg)
        begin
            col_next = '0;
            row_next = (in_row >= hlast_reg) ? '0 : in_row + RowW'(1);
        end
        else
        begin
            col_next = in_col + ColW'(1);
            row_next = in_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_emit_reg <= in_emit;
                fwd_hit_reg <= s1_valid_reg && (in_col == s1_col_reg);
            end
        end
    end

    // forward the entry written this cycle when the next pixel reads the same column
    always_comb
    begin
        cur_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        top_pix   = cur_entry[2*PixW-1:PixW];
        mid_pix   = cur_entry[PixW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg  <= line_mem[in_col];
            fwd_data_reg <= {mid_pix, s1_pix_reg};
            s1_col_reg   <= in_col;
            s1_pix_reg   <= s_tdata;
            s1_pos_reg   <= in_pos;
        end
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= {mid_pix, s1_pix_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (s1_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= top_pix;
                win_reg[5] <= mid_pix;
                win_reg[8] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_pos_reg <= s1_pos_reg;
        s3_pos_reg <= s2_pos_reg;
        s4_pos_reg <= s3_pos_reg;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        neg_reg    <= acc_reg[AccW-1];
        prod_reg   <= ProdW'(mag_next) * ProdW'(mul_const);
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            q[k] = $signed({{(AccW-PixW){1'b0}}, win_reg[k]});
        ring = q[0] + q[1] + q[2] + q[3] + q[5] + q[6] + q[7] + q[8];
        case (mode_reg)
            MODE_AVG:     acc_next = ring + q[4];
            MODE_GAUSS:   acc_next = q[0] + q[2] + q[6] + q[8]
                                     + ((q[1] + q[3] + q[5] + q[7]) <<< 1) + (q[4] <<< 2);
            MODE_PREWX:   acc_next = (q[2] + q[5] + q[8]) - (q[0] + q[3] + q[6]);
            MODE_PREWY:   acc_next = (q[6] + q[7] + q[8]) - (q[0] + q[1] + q[2]);
            MODE_SOBELX:  acc_next = (q[2] + (q[5] <<< 1) + q[8]) - (q[0] + (q[3] <<< 1) + q[6]);
            MODE_SOBELY:  acc_next = (q[6] + (q[7] <<< 1) + q[8]) - (q[0] + (q[1] <<< 1) + q[2]);
            MODE_LAPLACE: acc_next = (q[4] <<< 3) - ring;
            default:      acc_next = (q[4] <<< 3) + q[4] - ring;
        endcase
    end

    always_comb
    begin
        mag_next = acc_reg[AccW-1] ? MagW'(-acc_reg) : MagW'(acc_reg);
        case (mode_reg) inside
            MODE_AVG:               mul_const = MulW'(AvgMul);
            MODE_PREWX, MODE_PREWY: mul_const = MulW'(Div3Mul);
            default:                mul_const = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        case (mode_reg) inside
            MODE_AVG:                 res_pix = prod_reg[AvgShift +: PixW];
            MODE_GAUSS:               res_pix = mag_reg[4 +: PixW];
            MODE_PREWX, MODE_PREWY:   res_pix = prod_reg[Div3Shift +: PixW];
            MODE_SOBELX, MODE_SOBELY: res_pix = mag_reg[2 +: PixW];
            MODE_LAPLACE:             res_pix = mag_reg[3 +: PixW];
            default:
            begin
                if (neg_reg)
                    res_pix = '0;
                else if (mag_reg > MagW'(255))
                    res_pix = PixW'(255);
                else
                    res_pix = mag_reg[PixW-1:0];
            end
        endcase
    end

    assign push      = s4_valid_reg;
    assign pop       = m_tvalid && m_tready;
    assign inflight  = 3'(s1_valid_reg && s1_emit_reg) + 3'(s2_valid_reg)
                       + 3'(s3_valid_reg) + 3'(s4_valid_reg);
    assign occupancy = (FifoAw+2)'(count_reg) + (FifoAw+2)'(inflight);
    assign s_tready  = occupancy < (FifoAw+2)'(FifoDepth);

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= '{pos: s4_pos_reg, pix: res_pix};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FifoAw'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FifoAw'(1);
            if (push && !pop)
                count_reg <= count_reg + (FifoAw+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (FifoAw+1)'(1);
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {{(OutDataW-PixW-2*OutPosW){1'b0}}, head.pos.col, head.pos.row, head.pix};
    assign m_tlast  = head.pos.last;

endmodule

/* rtl/c3esf_checker.sv */
// Port-level checker of the 3x3 window filter, bound to the top level.
// Depends on c3esf_pkg and conv3x3_edge_smooth_filter_assert.svh.
`include "conv3x3_edge_smooth_filter_assert.svh"

module c3esf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [c3esf_pkg::OutDataW-1:0] m_tdata,
    input logic                           m_tlast
);
    import c3esf_pkg::*;

    // a stalled result beat holds
    `C3ESF_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // only interior centres leave the block
    `C3ESF_ASSERT_IMP(a_interior, clk, rst_n, m_tvalid, (m_tdata[17:8] != 10'd0) && (m_tdata[27:18] != 10'd0))

    // back-pressure on the input only while results are queued
    `C3ESF_ASSERT_IMP(a_stall_cause, clk, rst_n, !s_tready, m_tvalid)

endmodule

bind conv3x3_edge_smooth_filter c3esf_checker u_c3esf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* bench/conv3x3_edge_smooth_filter_checker.sv */
// Watches the pixel, result and register ports of the 3x3 window filter, predicts each
// filtered result and compares it against the result beats. Depends on c3esf_pkg.
module conv3x3_edge_smooth_filter_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel_in
    input  logic [0:0]                     s_tuser,   // [0] frame_start
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [c3esf_pkg::OutDataW-1:0] m_tdata,   // [7:0] pixel_out, [17:8] out_row,
                                                      // [27:18] out_col, [31:28] zero
    input  logic                           m_tlast,   // frame_done
    input  logic                           cfg_we,
    input  logic [c3esf_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [c3esf_pkg::CfgW-1:0]     cfg_data,
    output int                             fail_count,
    output int                             expected_count,
    output int                             pixels_seen,
    output int                             results_seen
);
    import c3esf_pkg::*;

    logic [PixW-1:0]  line_prev  [MaxWidth];
    logic [PixW-1:0]  line_older [MaxWidth];
    logic [PixW-1:0]  win [9];
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [CfgW-1:0]  width_reg;
    logic [CfgW-1:0]  height_reg;
    logic [ModeW-1:0] mode_reg;
    result_t          expected_results [$];
    result_t          oldest;

    initial
    begin
        for (int i = 0; i < MaxWidth; i++)
        begin
            line_prev[i]  = '0;
            line_older[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        row_pos        = 0;
        col_pos        = 0;
        width_reg      = 11'd512;
        height_reg     = 11'd512;
        mode_reg       = MODE_AVG;
        fail_count     = 0;
        expected_count = 0;
        pixels_seen    = 0;
        results_seen   = 0;
    end

    function automatic int unsigned clamp_dim(input logic [CfgW-1:0] v, input int unsigned maxv);
        if (v < 3)
            return 3;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [PixW-1:0] window_value();
        int p [9];
        int ring;
        int s;
        int res;
        for (int k = 0; k < 9; k++)
            p[k] = int'(win[k]);
        ring = p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8];
        case (mode_reg)
            MODE_AVG:     res = (ring + p[4]) * 11111 / 100000;
            MODE_GAUSS:   res = (p[0] + p[2] + p[6] + p[8] + 2 * (p[1] + p[3] + p[5] + p[7])
                                 + 4 * p[4]) / 16;
            MODE_PREWX:   res = magnitude((p[2] + p[5] + p[8]) - (p[0] + p[3] + p[6])) / 3;
            MODE_PREWY:   res = magnitude((p[6] + p[7] + p[8]) - (p[0] + p[1] + p[2])) / 3;
            MODE_SOBELX:  res = magnitude((p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6])) / 4;
            MODE_SOBELY:  res = magnitude((p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2])) / 4;
            MODE_LAPLACE: res = magnitude(8 * p[4] - ring) / 8;
            default:
            begin
                s = 9 * p[4] - ring;
                res = (s < 0) ? 0 : ((s > 255) ? 255 : s);
            end
        endcase
        return res[PixW-1:0];
    endfunction

    task automatic predict_pixel(input logic [PixW-1:0] pix, input logic fs);
        int unsigned     w;
        int unsigned     h;
        int unsigned     r;
        int unsigned     c;
        logic [PixW-1:0] top_pix;
        logic [PixW-1:0] mid_pix;
        result_t         res;
        w = clamp_dim(width_reg, MaxWidth);
        h = clamp_dim(height_reg, MaxHeight);
        if (fs)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        if (c < MaxWidth)
        begin
            top_pix       = line_older[c];
            mid_pix       = line_prev[c];
            line_older[c] = mid_pix;
            line_prev[c]  = pix;
        end
        else
        begin
            top_pix = '0;
            mid_pix = '0;
        end
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top_pix;
        win[5] = mid_pix;
        win[8] = pix;
        if (r >= 2 && c >= 2 && r < h && c < w)
        begin
            res.pix      = window_value();
            res.pos.row  = OutPosW'(r - 1);
            res.pos.col  = OutPosW'(c - 1);
            res.pos.last = (r == h - 1 && c == w - 1);
            expected_results.push_back(res);
        end
        if (c >= w - 1)
        begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    CFG_MODE:   mode_reg   = cfg_data[ModeW-1:0];
                    default:    ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_pixel(s_tdata, s_tuser[0]);
                pixels_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got pixel %0d row %0d col %0d",
                             $time, m_tdata[7:0], m_tdata[17:8], m_tdata[27:18]);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_field("pixel_out", int'(oldest.pix), int'(m_tdata[7:0]));
                    compare_field("out_row", int'(oldest.pos.row), int'(m_tdata[17:8]));
                    compare_field("out_col", int'(oldest.pos.col), int'(m_tdata[27:18]));
                    compare_field("frame_done", int'(oldest.pos.last), int'(m_tlast));
                    compare_field("tdata padding", 0, int'(m_tdata[31:28]));
                end
            end
            expected_count = expected_results.size();
        end
    end

endmodule

/* bench/conv3x3_edge_smooth_filter_tb.sv */
// Top of the 3x3 window filter bench: clock, reset, pixel and register stimulus, result
// back-pressure and verdict. Depends on c3esf_pkg, conv3x3_edge_smooth_filter and conv3x3_edge_smooth_filter_checker.
module conv3x3_edge_smooth_filter_tb;
    import c3esf_pkg::*;

    localparam int RandomItems   = 1150;
    localparam int StallCycles   = 400;
    localparam int SettleCycles  = 12;
    localparam int WatchdogLimit = 4000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgW-1:0]     cfg_data;

    int fail_count;
    int expected_count;
    int pixels_seen;
    int results_seen;
    int pixels_sent  = 0;
    int stall_req    = 0;
    int stall_done   = 0;
    int pixel_style  = 0;
    int phases       = 0;
    bit quiet        = 0;

    conv3x3_edge_smooth_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv3x3_edge_smooth_filter_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .expected_count (expected_count),
        .pixels_seen    (pixels_seen),
        .results_seen   (results_seen)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_pixel();
        logic [7:0] v;
        case (pixel_style)
            2:       v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            3:       v = 8'd120 + 8'($urandom_range(0, 16));
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    function automatic int pick_dim(input int top_small);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(3, top_small);
        if (r < 94)
            return $urandom_range(top_small + 1, 4 * top_small);
        return $urandom_range(0, 2);
    endfunction

    function automatic int eff_dim(input int v);
        return (v < 3) ? 3 : v;
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input bit do_w, input bit do_h, input bit do_m,
                             input int wv, input int hv, input logic [ModeW-1:0] mv);
        logic [7:0] junk;
        junk = 8'($urandom);
        if (do_w)
            write_reg(CFG_WIDTH, wv[CfgW-1:0]);
        if (do_h)
            write_reg(CFG_HEIGHT, hv[CfgW-1:0]);
        if (do_m)
            write_reg(CFG_MODE, {junk, mv});
        cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input logic [7:0] pix, input logic fs);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= pix;
        s_tuser[0] <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_run(input int count, input bit first_fs);
        for (int i = 0; i < count; i++)
            push_pixel(pick_pixel(), first_fs && i == 0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (!(pixels_seen == pixels_sent && expected_count == 0))
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // result side back-pressure
    initial
    begin
        int span;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_done < stall_req)
            begin
                m_tready <= 1'b0;
                repeat (StallCycles) @(posedge clk);
                stall_done++;
            end
            else
            begin
                span = pick_gap();
                if (span > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WatchdogLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Watchdog: no beat for %0d cycles at %0t", WatchdogLimit, $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int               kind;
        int               wv;
        int               hv;
        int               w;
        int               h;
        int               k;
        int               new_w;
        int               new_h;
        int               target;
        logic [ModeW-1:0] mode_sel;

        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_WIDTH;
        cfg_data   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // undersized registers clamp to 3x3; sharpen saturates both ways
        configure(1, 1, 1, 2, 1, MODE_SHARPEN);
        for (int i = 0; i < 9; i++)
            push_pixel((i == 4) ? 8'd255 : 8'd0, i == 0);
        for (int i = 0; i < 9; i++)
            push_pixel((i == 4) ? 8'd0 : 8'd255, 1'b0);
        settle();
        configure(0, 0, 1, 0, 0, MODE_AVG);
        for (int i = 0; i < 9; i++)
            push_pixel(8'd255, i == 0);

        target = pixels_sent + RandomItems;
        while (pixels_sent < target)
        begin
            settle();
            phases++;
            kind        = $urandom_range(0, 9);
            quiet       = ($urandom_range(0, 5) == 0);
            pixel_style = $urandom_range(0, 3);
            if (phases == 4)
                stall_req++;
            wv       = pick_dim(12);
            hv       = pick_dim(6);
            w        = eff_dim(wv);
            h        = eff_dim(hv);
            mode_sel = ModeW'($urandom_range(0, 7));
            if (kind <= 4)
            begin
                configure(1, 1, 1, wv, hv, mode_sel);
                send_run(w * h, 1'b1);
                if ($urandom_range(0, 2) == 0 && pixels_sent + w * h < target)
                    send_run(w * h, 1'b0);
            end
            else if (kind <= 6)
            begin
                configure(1, 1, 1, wv, hv, mode_sel);
                k = $urandom_range(1, w * h - 1);
                send_run(k, 1'b1);
                settle();
                mode_sel = ModeW'($urandom_range(0, 7));
                configure(0, 0, 1, 0, 0, mode_sel);
                send_run(w * h - k, 1'b0);
            end
            else if (kind <= 8)
            begin
                // shrink the frame while the position sits deep inside it
                configure(1, 1, 1, wv, hv, mode_sel);
                k = $urandom_range(2 * w, w * h - 1);
                send_run(k, 1'b1);
                settle();
                new_w = $urandom_range(3, w);
                new_h = $urandom_range(3, h);
                configure(1, 1, 0, new_w, new_h, mode_sel);
                send_run(new_w * new_h + $urandom_range(0, 2 * new_w), 1'b0);
            end
            else
            begin
                k = $urandom_range(10, 60);
                for (int i = 0; i < k; i++)
                    push_pixel(pick_pixel(), $urandom_range(0, 11) == 0);
            end
        end

        // a wide frame under a long result stall, then a tall narrow one
        settle();
        quiet       = 0;
        pixel_style = 0;
        mode_sel    = ModeW'($urandom_range(0, 7));
        wv          = $urandom_range(60, 100);
        configure(1, 1, 1, wv, 3, mode_sel);
        stall_req++;
        send_run(wv * 3, 1'b1);
        settle();
        mode_sel = ModeW'($urandom_range(0, 7));
        hv       = $urandom_range(30, 60);
        configure(1, 1, 1, 3, hv, mode_sel);
        send_run(3 * hv, 1'b1);
        settle();

        $display("Sent %0d pixels in %0d random phases plus directed, wide and tall frames;",
                 pixels_sent, phases);
        $display("checked %0d filtered results across all modes and resized frames.",
                 results_seen);
        if (fail_count == 0 && expected_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
